FILE: sv/circuit_switch_port_mapper_defines.svh
// assertion macros used by the rtl
`ifndef CIRCUIT_SWITCH_PORT_MAPPER_DEFINES_SVH
`define CIRCUIT_SWITCH_PORT_MAPPER_DEFINES_SVH

// check a property on the rising clock, off during reset
`define CSPM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on the rising clock, also during reset
`define CSPM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/cspm_pkg.sv
package cspm_pkg;

    localparam int NumPortsDefault = 64;
    localparam int MapDepth        = 64;
    localparam int KeyW            = 6;
    localparam int PortCountW      = 7;
    localparam logic [PortCountW-1:0] PortCountReset = 7'd64;

    localparam logic [7:0] ProtoUdp = 8'h11;
    localparam logic [7:0] ProtoTcp = 8'h06;
    localparam logic [7:0] ProtoAck = 8'hFC;
    localparam logic [7:0] ProtoNak = 8'hFD;
    localparam logic [7:0] ProtoCtl = 8'hFC;

    typedef enum logic [2:0] {
        CMD_PACKET      = 3'd0,
        CMD_CLR_ACTIVE  = 3'd1,
        CMD_WR_ACTIVE   = 3'd2,
        CMD_CLR_PENDING = 3'd3,
        CMD_WR_PENDING  = 3'd4,
        CMD_START       = 3'd5,
        CMD_TICK        = 3'd6,
        CMD_READ        = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_FORWARD  = 3'd0,
        ST_DROP_RCF = 3'd1,
        ST_DROP_UNM = 3'd2,
        ST_DROP_BAD = 3'd3,
        ST_ACCEPTED = 3'd4,
        ST_DUP      = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  in_port;
        logic [7:0]  map_out_port;
        logic [7:0]  l3_protocol;
        logic [2:0]  priority_group;
        logic [15:0] packet_length;
        logic [31:0] downtime_ticks;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_port;
        logic [2:0]  queue_index;
        logic        reconfiguring;
        logic [31:0] data_packets;
        logic [47:0] data_bytes;
        logic [31:0] ack_packets;
        logic [47:0] ack_bytes;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input word, issue memory reads
        logic exec;     // evaluate and update state, capture result
    } t_ctl_cmd;

    function automatic logic [2:0] queue_for(logic [7:0] proto, logic [2:0] pg);
        logic [2:0] q;
        if (proto >= ProtoCtl) q = 3'd0;
        else if (proto == ProtoTcp) q = 3'd1;
        else q = pg;
        return q;
    endfunction

endpackage

FILE: sv/cspm_ctrl.sv
`include "circuit_switch_port_mapper_defines.svh"

module cspm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output cspm_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec = (r_state == S_EXEC);

    `CSPM_ASSERT_ALWAYS(a_onehot, i_clk, !i_rst_n || $onehot(r_state), "state not one-hot")
    `CSPM_ASSERT(a_load_next, i_clk, i_rst_n, o_cmd.load |=> r_state == S_READ,
        "load not followed by read")
    `CSPM_ASSERT(a_exec_out, i_clk, i_rst_n, o_cmd.exec |=> o_valid,
        "exec not followed by result")
    `CSPM_ASSERT(a_hold_out, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid,
        "result dropped while stalled")

endmodule

FILE: sv/cspm_datapath.sv
module cspm_datapath #(
    parameter int NUM_PORTS = cspm_pkg::NumPortsDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cspm_pkg::t_ctl_cmd                i_cmd,
    input  cspm_pkg::t_in_word                i_word,
    input  logic                              i_cfg_valid,
    input  logic [cspm_pkg::PortCountW-1:0]   i_cfg_data,
    output cspm_pkg::t_out_word               o_word
);

    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int LW = $clog2(NUM_PORTS + 1);
    localparam int MD = cspm_pkg::MapDepth;

    // map storage: flip-flops, two banks with a single bank select (swap = flip)
    logic [7:0]    r_tgt_a [MD];
    logic [7:0]    r_tgt_b [MD];
    logic [MD-1:0] r_vld_a, r_vld_b;
    logic          r_act_b;
    logic          r_rcf;
    logic [31:0]   r_dt;
    logic [cspm_pkg::PortCountW-1:0] r_pcnt;

    // counter memories
    logic [31:0] m_dp [NUM_PORTS];
    logic [47:0] m_db [NUM_PORTS];
    logic [31:0] m_ap [NUM_PORTS];
    logic [47:0] m_ab [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_cnt_ok;

    cspm_pkg::t_in_word r_in;
    logic [31:0] r_dp, r_ap;
    logic [47:0] r_db, r_ab;
    logic        r_rd_ok;
    logic [7:0]  r_dst;
    logic [PW-1:0] r_dst_idx;

    logic [5:0] key;
    logic [7:0] act_tgt;
    logic       act_vld, pen_vld;
    logic [7:0] ld_tgt;
    logic [LW-1:0] limit;
    logic       is_udp, is_ack, bad, fwd, rd_in;
    logic [PW-1:0] ld_idx;

    assign key = r_in.in_port;
    assign ld_tgt = r_act_b ? r_tgt_b[i_word.in_port] : r_tgt_a[i_word.in_port];
    assign act_vld = r_act_b ? r_vld_b[key] : r_vld_a[key];
    assign pen_vld = r_act_b ? r_vld_a[key] : r_vld_b[key];
    assign act_tgt = r_dst;
    assign ld_idx = PW'(ld_tgt);
    assign rd_in  = ({3'b0, i_word.in_port} < 9'(NUM_PORTS));

    always_comb begin
        if ({2'b0, r_pcnt} < 9'(NUM_PORTS)) limit = LW'(r_pcnt);
        else limit = LW'(NUM_PORTS);
    end

    // memory stage: read counters for either the mapped port or the read port
    logic [PW-1:0] rd_addr;
    always_comb begin
        if (i_word.command == cspm_pkg::CMD_READ) rd_addr = PW'(i_word.in_port);
        else rd_addr = ld_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in      <= i_word;
            r_dst     <= ld_tgt;
            r_dst_idx <= rd_addr;
            r_rd_ok   <= (i_word.command == cspm_pkg::CMD_READ) ? rd_in
                       : ({8'd0, ld_tgt} < 16'(NUM_PORTS));
            r_dp <= m_dp[rd_addr];
            r_db <= m_db[rd_addr];
            r_ap <= m_ap[rd_addr];
            r_ab <= m_ab[rd_addr];
        end
    end

    assign is_udp = (r_in.l3_protocol == cspm_pkg::ProtoUdp);
    assign is_ack = (r_in.l3_protocol == cspm_pkg::ProtoAck)
                 || (r_in.l3_protocol == cspm_pkg::ProtoNak);
    assign bad    = ({1'b0, act_tgt} >= 9'(limit));
    assign fwd    = (r_in.command == cspm_pkg::CMD_PACKET) && !r_rcf && act_vld && !bad;

    logic        cok;
    logic [31:0] c_dp, c_ap;
    logic [47:0] c_db, c_ab;
    assign cok  = r_cnt_ok[r_dst_idx] && r_rd_ok;
    assign c_dp = cok ? r_dp : 32'd0;
    assign c_db = cok ? r_db : 48'd0;
    assign c_ap = cok ? r_ap : 32'd0;
    assign c_ab = cok ? r_ab : 48'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && fwd && (is_udp || is_ack)) begin
            if (is_udp) begin
                m_dp[r_dst_idx] <= c_dp + 32'd1;
                m_db[r_dst_idx] <= c_db + {32'd0, r_in.packet_length};
                m_ap[r_dst_idx] <= c_ap;
                m_ab[r_dst_idx] <= c_ab;
            end else begin
                m_dp[r_dst_idx] <= c_dp;
                m_db[r_dst_idx] <= c_db;
                m_ap[r_dst_idx] <= c_ap + 32'd1;
                m_ab[r_dst_idx] <= c_ab + {32'd0, r_in.packet_length};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt_ok <= '0;
        else if (i_cmd.exec && fwd && (is_udp || is_ack)) r_cnt_ok[r_dst_idx] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pcnt <= cspm_pkg::PortCountReset;
        else if (i_cfg_valid) r_pcnt <= i_cfg_data;
    end

    // map and reconfiguration state
    logic n_rcf;
    always_comb begin
        n_rcf = r_rcf;
        if (r_in.command == cspm_pkg::CMD_CLR_ACTIVE) n_rcf = 1'b0;
        else if (r_in.command == cspm_pkg::CMD_START) n_rcf = 1'b1;
        else if (r_in.command == cspm_pkg::CMD_TICK && r_rcf && r_dt <= 32'd1) n_rcf = 1'b0;
    end

    logic wr_a, wr_b;
    assign wr_a = (r_in.command == cspm_pkg::CMD_WR_ACTIVE && !act_vld && !r_act_b)
               || (r_in.command == cspm_pkg::CMD_WR_PENDING && !pen_vld && r_act_b);
    assign wr_b = (r_in.command == cspm_pkg::CMD_WR_ACTIVE && !act_vld && r_act_b)
               || (r_in.command == cspm_pkg::CMD_WR_PENDING && !pen_vld && !r_act_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_a) r_tgt_a[key] <= r_in.map_out_port;
        if (i_cmd.exec && wr_b) r_tgt_b[key] <= r_in.map_out_port;
    end

    logic swap, clr_act, clr_pen;
    assign swap    = r_in.command == cspm_pkg::CMD_TICK && r_rcf && r_dt <= 32'd1;
    assign clr_act = r_in.command == cspm_pkg::CMD_CLR_ACTIVE;
    assign clr_pen = r_in.command == cspm_pkg::CMD_CLR_PENDING;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
            r_act_b <= 1'b0;
            r_rcf   <= 1'b0;
            r_dt    <= 32'd0;
        end else if (i_cmd.exec) begin
            r_rcf <= n_rcf;
            if (wr_a) r_vld_a[key] <= 1'b1;
            if (wr_b) r_vld_b[key] <= 1'b1;
            if (swap) begin
                // old active bank becomes the empty pending bank
                r_act_b <= !r_act_b;
                if (r_act_b) r_vld_b <= '0;
                else r_vld_a <= '0;
                r_dt <= 32'd0;
            end else if (clr_act) begin
                if (r_act_b) r_vld_b <= '0;
                else r_vld_a <= '0;
                r_dt <= 32'd0;
            end else if (clr_pen) begin
                if (r_act_b) r_vld_a <= '0;
                else r_vld_b <= '0;
            end else if (r_in.command == cspm_pkg::CMD_START) begin
                r_dt <= r_in.downtime_ticks;
            end else if (r_in.command == cspm_pkg::CMD_TICK && r_rcf) begin
                r_dt <= r_dt - 32'd1;
            end
        end
    end

    // result register
    cspm_pkg::t_out_word n_word;
    always_comb begin
        n_word = '0;
        n_word.status = cspm_pkg::ST_ACCEPTED;
        n_word.reconfiguring = n_rcf;
        unique case (r_in.command)
            cspm_pkg::CMD_PACKET: begin
                if (r_rcf) n_word.status = cspm_pkg::ST_DROP_RCF;
                else if (!act_vld) n_word.status = cspm_pkg::ST_DROP_UNM;
                else begin
                    n_word.out_port = act_tgt;
                    if (bad) n_word.status = cspm_pkg::ST_DROP_BAD;
                    else begin
                        n_word.status = cspm_pkg::ST_FORWARD;
                        n_word.queue_index = cspm_pkg::queue_for(r_in.l3_protocol,
                            r_in.priority_group);
                    end
                end
            end
            cspm_pkg::CMD_WR_ACTIVE:
                if (act_vld) n_word.status = cspm_pkg::ST_DUP;
            cspm_pkg::CMD_WR_PENDING:
                if (pen_vld) n_word.status = cspm_pkg::ST_DUP;
            cspm_pkg::CMD_READ: begin
                n_word.data_packets = c_dp;
                n_word.data_bytes   = c_db;
                n_word.ack_packets  = c_ap;
                n_word.ack_bytes    = c_ab;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) o_word <= n_word;
    end

endmodule

FILE: sv/circuit_switch_port_mapper.sv
// an accepted input word passes the read and exec states; the result word is
// registered in exec and held in the out state while the output is stalled;
// new words are taken only in idle; one counter read and one write per word
// reset: synchronous active-low; maps empty, counters read as zero, port_count 64
// no clearing pass: counter entries carry valid bits cleared at reset
module circuit_switch_port_mapper #(
    parameter int NUM_PORTS = cspm_pkg::NumPortsDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  cspm_pkg::t_in_word              i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output cspm_pkg::t_out_word             o_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cspm_pkg::PortCountW-1:0] i_cfg_data
);

    cspm_pkg::t_ctl_cmd cmd;

    assign o_cfg_ready = 1'b1;

    cspm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    cspm_datapath #(.NUM_PORTS(NUM_PORTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_word      (o_data)
    );

endmodule
